@@ sv/plb_pkg.sv @@
// ---------------------------------------------------------------------------
// plb_pkg: shared types and constants for the slot binder
// Field widths, request and status codes, controller states and the layout
// of one slot entry as it sits in the slot memory.
// ---------------------------------------------------------------------------
package plb_pkg;

   localparam int MAX_SLOTS_DEF = 8;

   localparam int ID_W       = 32;
   localparam int PRIO_W     = 4;
   localparam int STAMP_W    = 32;
   localparam int HITS_W     = 32;
   localparam int CFG_CNT_W  = 4;
   localparam int SLOT_SEL_W = 6;
   localparam int SLOT_IDX_W = 3;
   localparam int STATUS_W   = 3;
   localparam int REQ_TYPE_W = 2;

   // wide enough for any slot count or index up to 64
   localparam int EXT_W      = 7;
   localparam int IDX_EXT_W  = 6;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [ID_W-1:0]      EMPTY_ID       = '1;
   localparam logic [CFG_CNT_W-1:0] SLOT_COUNT_RST = 4'd8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ATTACH   = 2'd0,
      REQ_EXPLICIT = 2'd1,
      REQ_DETACH   = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_HIT      = 3'd0,
      STS_FREE     = 3'd1,
      STS_EVICT    = 3'd2,
      STS_NOSLOT   = 3'd3,
      STS_NOTFOUND = 3'd4,
      STS_BADINDEX = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      SM_IDLE,
      SM_SCAN,
      SM_EXPL,
      SM_DECIDE,
      SM_RESP
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    res;
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] stamp;
      logic [HITS_W-1:0]  hits;
   } slot_entry_type;

endpackage

@@ sv/priority_lru_slot_binder.sv @@
// ---------------------------------------------------------------------------
// priority_lru_slot_binder: fully associative binding slots, priority + LRU
// Requests attach, bind to a given slot, detach or clear. Slot contents live
// in a memory with a registered read port that is walked one slot per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   Request words come in on req_* (valid/stall) and each one gives exactly
//   one response word on rsp_* (valid/stall). slot_count is set through the
//   csr_* APB port, register 0 at byte address 0; the user must set it only
//   while idle, as the block does not enforce this. An attach or detach
//   walks the first n = min(slot_count, MAX_SLOTS) slots, one slot per
//   cycle through the memory read port, and stops early on a hit; an attach
//   that misses then picks a free or victim slot. An explicit attach reads
//   only its given slot; a clear or a rejected request goes straight to
//   the response. A new request is taken only in the idle state, once the
//   previous response has moved to the output register.
//   Reset empties all slots at once (per-slot valid flags), zeros the use
//   counter and sets slot_count to 8. No clearing pass is needed.
//   While rsp_stall holds a response in the output register, one more
//   request may be accepted and processed; it then waits in the controller
//   until the output register frees up.
// ---------------------------------------------------------------------------
module priority_lru_slot_binder
   import plb_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [ID_W-1:0]        req_res_id,
   input  logic [PRIO_W-1:0]      req_priority,
   input  logic [SLOT_SEL_W-1:0]  req_slot_sel,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_IDX_W-1:0]  rsp_slot_index,
   output logic [HITS_W-1:0]      rsp_hit_count,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // slot memory
   slot_entry_type        slot_mem [MAX_SLOTS];
   slot_entry_type        rd_data_ff;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   slot_entry_type        wr_data;

   // control state
   state_type             state_ff, state_in;
   logic [MAX_SLOTS-1:0]  valid_ff, valid_in;
   logic [CFG_CNT_W-1:0]  slot_count_ff, slot_count_in;
   logic [STAMP_W-1:0]    use_counter_ff, use_counter_in;
   logic [CNT_W-1:0]      chk_cnt_ff, chk_cnt_in;
   logic                  have_free_ff, have_free_in;
   logic                  have_vic_ff, have_vic_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request and scan payload
   req_kind_type          kind_ff, kind_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [PRIO_W-1:0]     prio_ff, prio_in;
   logic [SLOT_W-1:0]     sel_idx_ff, sel_idx_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0]     vic_idx_ff, vic_idx_in;
   logic [PRIO_W-1:0]     min_prio_ff, min_prio_in;
   logic [STAMP_W-1:0]    vic_stamp_ff, vic_stamp_in;
   status_type            res_status_ff, res_status_in;
   logic [SLOT_W-1:0]     res_idx_ff, res_idx_in;
   logic [HITS_W-1:0]     res_hits_ff, res_hits_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [HITS_W-1:0]     rsp_hits_ff, rsp_hits_in;

   // decode helpers
   logic                  req_acc;
   req_kind_type          req_kind;
   logic [CNT_W-1:0]      n_slots;
   logic                  n_zero;
   logic                  req_empty_id;
   logic                  sel_bad;
   logic [SLOT_W-1:0]     chk_idx;
   logic [CNT_W-1:0]      nxt_cnt;
   logic                  scan_last;
   logic [SLOT_W-1:0]     cur_idx;
   logic                  cur_valid;
   slot_entry_type        view;
   logic                  cur_match;
   logic                  better_vic;
   logic                  out_free;
   logic [IDX_EXT_W-1:0]  rsp_idx_ext;

   // ------------------------------------------------------------------------
   // CSR port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(slot_count_ff);

   // single register at address 0
   always_comb begin
      slot_count_in = slot_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == '0)) begin
         slot_count_in = csr_pwdata[CFG_CNT_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Decode
   // ------------------------------------------------------------------------
   assign req_stall    = (state_ff != SM_IDLE);
   assign req_acc      = req_valid && !req_stall;
   assign req_kind     = req_kind_type'(req_type);
   assign req_empty_id = (req_res_id == EMPTY_ID);

   always_comb begin
      if (int'(slot_count_ff) < MAX_SLOTS) begin
         n_slots = CNT_W'(slot_count_ff);
      end else begin
         n_slots = CNT_W'(MAX_SLOTS);
      end
   end

   assign n_zero    = (n_slots == '0);
   assign sel_bad   = (EXT_W'(req_slot_sel) >= EXT_W'(n_slots));
   assign chk_idx   = chk_cnt_ff[SLOT_W-1:0];
   assign nxt_cnt   = chk_cnt_ff + 1'b1;
   assign scan_last = (nxt_cnt == n_slots);
   assign cur_idx   = (state_ff == SM_EXPL) ? sel_idx_ff : chk_idx;
   assign cur_valid = valid_ff[cur_idx];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a slot without its valid flag reads as an empty, zeroed entry
   always_comb begin
      if (cur_valid) begin
         view = rd_data_ff;
      end else begin
         view = '{res: EMPTY_ID, prio: '0, stamp: '0, hits: '0};
      end
   end

   assign cur_match  = cur_valid && (view.res == id_ff);
   assign better_vic = !have_vic_ff || (view.prio < min_prio_ff) ||
                       ((view.prio == min_prio_ff) && (view.stamp < vic_stamp_ff));

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SM_IDLE: begin
            if (req_acc) begin
               unique case (req_kind)
                  REQ_ATTACH, REQ_DETACH: begin
                     state_in = (req_empty_id || n_zero) ? SM_RESP : SM_SCAN;
                  end
                  REQ_EXPLICIT: begin
                     state_in = (sel_bad || req_empty_id) ? SM_RESP : SM_EXPL;
                  end
                  REQ_CLEAR: begin
                     state_in = SM_RESP;
                  end
                  default: begin
                     state_in = SM_RESP;
                  end
               endcase
            end
         end
         SM_SCAN: begin
            if (cur_match) begin
               state_in = SM_RESP;
            end else if (scan_last) begin
               state_in = (kind_ff == REQ_ATTACH) ? SM_DECIDE : SM_RESP;
            end
         end
         SM_EXPL: begin
            state_in = SM_RESP;
         end
         SM_DECIDE: begin
            state_in = SM_RESP;
         end
         SM_RESP: begin
            if (out_free) begin
               state_in = SM_IDLE;
            end
         end
         default: begin
            state_in = SM_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and memory control
   // ------------------------------------------------------------------------
   always_comb begin
      kind_in        = kind_ff;
      id_in          = id_ff;
      prio_in        = prio_ff;
      sel_idx_in     = sel_idx_ff;
      chk_cnt_in     = chk_cnt_ff;
      have_free_in   = have_free_ff;
      free_idx_in    = free_idx_ff;
      have_vic_in    = have_vic_ff;
      vic_idx_in     = vic_idx_ff;
      min_prio_in    = min_prio_ff;
      vic_stamp_in   = vic_stamp_ff;
      res_status_in  = res_status_ff;
      res_idx_in     = res_idx_ff;
      res_hits_in    = res_hits_ff;
      valid_in       = valid_ff;
      use_counter_in = use_counter_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = cur_idx;
      wr_data        = '{res: id_ff, prio: prio_ff, stamp: use_counter_ff, hits: '0};
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_hits_in    = rsp_hits_ff;

      unique case (state_ff)
         SM_IDLE: begin
            if (req_acc) begin
               kind_in       = req_kind;
               id_in         = req_res_id;
               prio_in       = req_priority;
               sel_idx_in    = req_slot_sel[SLOT_W-1:0];
               chk_cnt_in    = '0;
               have_free_in  = 1'b0;
               have_vic_in   = 1'b0;
               res_status_in = STS_HIT;
               res_idx_in    = '0;
               res_hits_in   = '0;
               unique case (req_kind)
                  REQ_ATTACH: begin
                     if (req_empty_id || n_zero) begin
                        res_status_in = STS_NOSLOT;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  REQ_EXPLICIT: begin
                     if (sel_bad) begin
                        res_status_in = STS_BADINDEX;
                     end else if (req_empty_id) begin
                        res_status_in = STS_NOSLOT;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = req_slot_sel[SLOT_W-1:0];
                     end
                  end
                  REQ_DETACH: begin
                     if (req_empty_id || n_zero) begin
                        res_status_in = STS_NOTFOUND;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     valid_in = '0;
                  end
               endcase
            end
         end

         SM_SCAN: begin
            if (cur_match) begin
               res_status_in = STS_HIT;
               res_idx_in    = chk_idx;
               if (kind_ff == REQ_ATTACH) begin
                  wr_en          = 1'b1;
                  wr_addr        = chk_idx;
                  wr_data.hits   = view.hits + 1'b1;
                  use_counter_in = use_counter_ff + 1'b1;
                  res_hits_in    = view.hits + 1'b1;
               end else begin
                  valid_in[chk_idx] = 1'b0;
                  res_hits_in       = '0;
               end
            end else begin
               if (!cur_valid && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = chk_idx;
               end
               // lowest priority, then oldest stamp, lowest index on a tie
               if (better_vic) begin
                  have_vic_in  = 1'b1;
                  vic_idx_in   = chk_idx;
                  min_prio_in  = view.prio;
                  vic_stamp_in = view.stamp;
               end
               if (scan_last) begin
                  res_status_in = STS_NOTFOUND;
                  res_idx_in    = '0;
                  res_hits_in   = '0;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = nxt_cnt[SLOT_W-1:0];
                  chk_cnt_in = nxt_cnt;
               end
            end
         end

         SM_DECIDE: begin
            res_hits_in = '0;
            if (have_free_ff) begin
               wr_en               = 1'b1;
               wr_addr             = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               use_counter_in      = use_counter_ff + 1'b1;
               res_status_in       = STS_FREE;
               res_idx_in          = free_idx_ff;
            end else if (have_vic_ff && (min_prio_ff <= prio_ff)) begin
               wr_en               = 1'b1;
               wr_addr             = vic_idx_ff;
               valid_in[vic_idx_ff] = 1'b1;
               use_counter_in      = use_counter_ff + 1'b1;
               res_status_in       = STS_EVICT;
               res_idx_in          = vic_idx_ff;
            end else begin
               res_status_in = STS_NOSLOT;
               res_idx_in    = '0;
            end
         end

         SM_EXPL: begin
            res_idx_in = sel_idx_ff;
            if (cur_match) begin
               res_status_in = STS_HIT;
               res_hits_in   = view.hits;
            end else begin
               wr_en                = 1'b1;
               wr_addr              = sel_idx_ff;
               wr_data.prio         = '0;
               valid_in[sel_idx_ff] = 1'b1;
               use_counter_in       = use_counter_ff + 1'b1;
               res_status_in        = cur_valid ? STS_EVICT : STS_FREE;
               res_hits_in          = '0;
            end
         end

         SM_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_hits_in   = res_hits_ff;
            end
         end

         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Memory
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SM_IDLE;
         valid_ff       <= '0;
         slot_count_ff  <= SLOT_COUNT_RST;
         use_counter_ff <= '0;
         chk_cnt_ff     <= '0;
         have_free_ff   <= 1'b0;
         have_vic_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         slot_count_ff  <= slot_count_in;
         use_counter_ff <= use_counter_in;
         chk_cnt_ff     <= chk_cnt_in;
         have_free_ff   <= have_free_in;
         have_vic_ff    <= have_vic_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      sel_idx_ff    <= sel_idx_in;
      free_idx_ff   <= free_idx_in;
      vic_idx_ff    <= vic_idx_in;
      min_prio_ff   <= min_prio_in;
      vic_stamp_ff  <= vic_stamp_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_hits_ff   <= res_hits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_hits_ff   <= rsp_hits_in;
   end

   // ------------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------------
   assign rsp_idx_ext    = IDX_EXT_W'(rsp_idx_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_idx_ext[SLOT_IDX_W-1:0];
   assign rsp_hit_count  = rsp_hits_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written slot not marked valid");

   a_counter_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (use_counter_ff != $past(use_counter_ff))) |-> $past(wr_en))
      else $error("use counter advanced without a slot write");

   a_clear_empties_all: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_kind == REQ_CLEAR)) |=> (valid_ff == '0))
      else $error("clear left a slot valid");

   a_new_bind_zero_hits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff == STS_FREE) || (rsp_status_ff == STS_EVICT) ||
                        (rsp_status_ff == STS_NOSLOT))) |-> (rsp_hits_ff == '0))
      else $error("new bind or failure reports nonzero hit count");

endmodule

@@ test/priority_lru_slot_binder_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_lru_slot_binder_test: self-checking bench for the slot binder
// A short table of directed requests, then random request words from small
// id pools over a series of slot_count settings. Every response word is
// checked against the typed table row or a cycle-free slot-array predictor.
// ---------------------------------------------------------------------------
module priority_lru_slot_binder_test
   import plb_pkg::*;
;

   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 120;
   localparam int POOL_MAX      = 12;
   localparam int N_DIR         = 24;
   localparam int N_PHASES      = 9;
   localparam int HOLD_PHASE    = 4;
   localparam int DRAIN_PHASE   = 6;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SLOT_COUNT = '0;

   typedef struct packed {
      req_kind_type          kind;
      logic [ID_W-1:0]       id;
      logic [PRIO_W-1:0]     prio;
      logic [SLOT_SEL_W-1:0] sel;
   } bind_req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_IDX_W-1:0] slot;
      logic [HITS_W-1:0]     hits;
   } bind_rsp_type;

   typedef struct packed {
      logic         typed;
      bind_req_type req;
      bind_rsp_type rsp;
   } dir_row_type;

   localparam bind_rsp_type NO_RSP = '{STS_HIT, 3'd0, 32'd0};

   // typed rows are readable straight off the slot state; the rest go to the predictor
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{1'b1, '{REQ_ATTACH,   32'h0000_0000, 4'd0,  6'd0},  '{STS_FREE,     3'd0, 32'd0}},
      '{1'b1, '{REQ_ATTACH,   32'hFFFF_FFFE, 4'd15, 6'd0},  '{STS_FREE,     3'd1, 32'd0}},
      '{1'b1, '{REQ_ATTACH,   32'h0000_0000, 4'd3,  6'd0},  '{STS_HIT,      3'd0, 32'd1}},
      '{1'b1, '{REQ_ATTACH,   EMPTY_ID,      4'd15, 6'd63}, '{STS_NOSLOT,   3'd0, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, 32'h0000_0001, 4'd0,  6'd63}, '{STS_BADINDEX, 3'd0, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, EMPTY_ID,      4'd0,  6'd7},  '{STS_NOSLOT,   3'd0, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, 32'hFFFF_FFFE, 4'd0,  6'd1},  '{STS_HIT,      3'd1, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, 32'h1234_5678, 4'd9,  6'd2},  '{STS_FREE,     3'd2, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, 32'hA5A5_A5A5, 4'd0,  6'd2},  '{STS_EVICT,    3'd2, 32'd0}},
      '{1'b1, '{REQ_DETACH,   32'h1234_5678, 4'd0,  6'd0},  '{STS_NOTFOUND, 3'd0, 32'd0}},
      '{1'b1, '{REQ_DETACH,   EMPTY_ID,      4'd0,  6'd0},  '{STS_NOTFOUND, 3'd0, 32'd0}},
      '{1'b1, '{REQ_DETACH,   32'hA5A5_A5A5, 4'd0,  6'd0},  '{STS_HIT,      3'd2, 32'd0}},
      '{1'b1, '{REQ_EXPLICIT, 32'h0000_0077, 4'd0,  6'd8},  '{STS_BADINDEX, 3'd0, 32'd0}},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0100, 4'd5,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0101, 4'd9,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0102, 4'd9,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0103, 4'd2,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0104, 4'd7,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0105, 4'd6,  6'd0},  NO_RSP},
      // full array, lowest stored priority 2: below it fails, at it evicts
      '{1'b0, '{REQ_ATTACH,   32'h0000_0300, 4'd1,  6'd0},  NO_RSP},
      '{1'b0, '{REQ_ATTACH,   32'h0000_0301, 4'd2,  6'd0},  NO_RSP},
      '{1'b1, '{REQ_CLEAR,    32'h0000_0000, 4'd0,  6'd0},  '{STS_HIT,      3'd0, 32'd0}},
      '{1'b1, '{REQ_DETACH,   32'h0000_0000, 4'd0,  6'd0},  '{STS_NOTFOUND, 3'd0, 32'd0}},
      '{1'b1, '{REQ_ATTACH,   32'h0000_0005, 4'd15, 6'd0},  '{STS_FREE,     3'd0, 32'd0}}
   };

   localparam int PH_COUNT [N_PHASES] = '{1, 15, 0, 3, 8, 2, 6, 5, 4};
   localparam int PH_ITEMS [N_PHASES] = '{150, 250, 40, 200, 300, 150, 250, 200, 210};

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [REQ_TYPE_W-1:0] req_type     = '0;
   logic [ID_W-1:0]       req_res_id   = '0;
   logic [PRIO_W-1:0]     req_priority = '0;
   logic [SLOT_SEL_W-1:0] req_slot_sel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_IDX_W-1:0] rsp_slot_index;
   logic [HITS_W-1:0]     rsp_hit_count;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicted slot array
   logic [ID_W-1:0]      bound_id    [MAX_SLOTS_DEF];
   logic [PRIO_W-1:0]    bound_prio  [MAX_SLOTS_DEF];
   logic [STAMP_W-1:0]   bound_stamp [MAX_SLOTS_DEF];
   logic [HITS_W-1:0]    bound_hits  [MAX_SLOTS_DEF];
   logic [STAMP_W-1:0]   use_ctr;
   logic [CFG_CNT_W-1:0] cfg_count;

   bind_rsp_type    owed_rsp [$];
   logic [ID_W-1:0] id_pool [POOL_MAX];
   int              pool_n;
   int              err_count = 0;
   int              words_sent = 0;
   int              status_tally [6] = '{0, 0, 0, 0, 0, 0};
   int              idle_cycles = 0;
   bit              hold_off_req = 1'b0;

   priority_lru_slot_binder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_res_id     (req_res_id),
      .req_priority   (req_priority),
      .req_slot_sel   (req_slot_sel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_hit_count  (rsp_hit_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic void vacate(input int i);
      bound_id[i]    = EMPTY_ID;
      bound_prio[i]  = '0;
      bound_stamp[i] = '0;
      bound_hits[i]  = '0;
   endfunction

   function automatic void occupy(input int i, input logic [ID_W-1:0] id,
                                  input logic [PRIO_W-1:0] p);
      bound_id[i]    = id;
      bound_stamp[i] = use_ctr;
      use_ctr        = use_ctr + 1;
      bound_prio[i]  = p;
      bound_hits[i]  = '0;
   endfunction

   function automatic bind_rsp_type bind_predict(input bind_req_type w);
      bind_rsp_type   o;
      int             n, hit_i, free_i, vic_i;
      logic [PRIO_W:0] low_prio;
      o = NO_RSP;
      n = (cfg_count < MAX_SLOTS_DEF) ? int'(cfg_count) : MAX_SLOTS_DEF;
      hit_i = -1;
      free_i = -1;
      vic_i = -1;
      case (w.kind)
         REQ_ATTACH: begin
            if (w.id == EMPTY_ID) begin
               o.status = STS_NOSLOT;
            end else begin
               for (int i = 0; i < n; i++) begin
                  if (hit_i < 0 && bound_id[i] == w.id) hit_i = i;
                  if (free_i < 0 && bound_id[i] == EMPTY_ID) free_i = i;
               end
               if (hit_i >= 0) begin
                  bound_stamp[hit_i] = use_ctr;
                  use_ctr = use_ctr + 1;
                  bound_prio[hit_i] = w.prio;
                  bound_hits[hit_i] = bound_hits[hit_i] + 1;
                  o = '{STS_HIT, SLOT_IDX_W'(hit_i), bound_hits[hit_i]};
               end else if (free_i >= 0) begin
                  occupy(free_i, w.id, w.prio);
                  o = '{STS_FREE, SLOT_IDX_W'(free_i), '0};
               end else begin
                  low_prio = 5'd16;
                  for (int i = 0; i < n; i++)
                     if ({1'b0, bound_prio[i]} < low_prio) low_prio = {1'b0, bound_prio[i]};
                  if (low_prio <= {1'b0, w.prio}) begin
                     for (int i = 0; i < n; i++)
                        if ({1'b0, bound_prio[i]} == low_prio &&
                            (vic_i < 0 || bound_stamp[i] < bound_stamp[vic_i])) vic_i = i;
                  end
                  if (vic_i < 0) begin
                     o.status = STS_NOSLOT;
                  end else begin
                     occupy(vic_i, w.id, w.prio);
                     o = '{STS_EVICT, SLOT_IDX_W'(vic_i), '0};
                  end
               end
            end
         end
         REQ_EXPLICIT: begin
            if (int'(w.sel) >= n) begin
               o.status = STS_BADINDEX;
            end else if (w.id == EMPTY_ID) begin
               o.status = STS_NOSLOT;
            end else if (bound_id[w.sel] == w.id) begin
               o = '{STS_HIT, SLOT_IDX_W'(w.sel), bound_hits[w.sel]};
            end else begin
               o = '{(bound_id[w.sel] == EMPTY_ID) ? STS_FREE : STS_EVICT,
                     SLOT_IDX_W'(w.sel), '0};
               occupy(int'(w.sel), w.id, '0);
            end
         end
         REQ_DETACH: begin
            if (w.id != EMPTY_ID)
               for (int i = 0; i < n; i++)
                  if (hit_i < 0 && bound_id[i] == w.id) hit_i = i;
            if (hit_i >= 0) begin
               vacate(hit_i);
               o = '{STS_HIT, SLOT_IDX_W'(hit_i), '0};
            end else begin
               o.status = STS_NOTFOUND;
            end
         end
         default: begin
            // clear empties every built slot, the use counter carries on
            for (int i = 0; i < MAX_SLOTS_DEF; i++) vacate(i);
         end
      endcase
      return o;
   endfunction

   function automatic bind_req_type make_request();
      bind_req_type w;
      int           pick;
      pick   = $urandom_range(0, 99);
      w.kind = REQ_ATTACH;
      w.id   = id_pool[$urandom_range(0, pool_n - 1)];
      w.prio = PRIO_W'($urandom_range(0, 15));
      w.sel  = SLOT_SEL_W'($urandom_range(0, 9));
      if (pick >= 91) begin
         // noise: any kind, any id, any slot
         w.kind = req_kind_type'($urandom_range(0, 3));
         w.id   = ($urandom_range(0, 2) == 0) ? EMPTY_ID : ID_W'($urandom);
         w.sel  = SLOT_SEL_W'($urandom);
      end else if (pick >= 88) begin
         w.kind = REQ_CLEAR;
      end else if (pick >= 70) begin
         w.kind = REQ_DETACH;
      end else if (pick >= 55) begin
         w.kind = REQ_EXPLICIT;
         if ($urandom_range(0, 4) == 0) w.sel = SLOT_SEL_W'($urandom);
      end
      return w;
   endfunction

   task automatic push_word(input bind_req_type w, input logic typed,
                            input bind_rsp_type typed_rsp);
      bind_rsp_type got;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= w.kind;
      req_res_id   <= w.id;
      req_priority <= w.prio;
      req_slot_sel <= w.sel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = bind_predict(w);
      if (typed) got = typed_rsp;
      status_tally[got.status]++;
      owed_rsp.push_back(got);
      words_sent++;
   endtask

   task automatic req_idle(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_results_done();
      req_idle(1);
      while (owed_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_set_count(input logic [CFG_CNT_W-1:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_SLOT_COUNT;
      csr_pwdata  <= CSR_DATA_W'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cfg_count = v;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[CFG_CNT_W-1:0] !== v) begin
         $error("slot_count readback: expected %0d, actual %0d", v, csr_prdata[CFG_CNT_W-1:0]);
         err_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // request side
   initial begin : stimulus
      int eff, sent, burst, gap;
      for (int i = 0; i < MAX_SLOTS_DEF; i++) vacate(i);
      use_ctr   = '0;
      cfg_count = SLOT_COUNT_RST;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (int d = 0; d < N_DIR; d++) begin
         push_word(DIR_ROWS[d].req, DIR_ROWS[d].typed, DIR_ROWS[d].rsp);
         if ($urandom_range(0, 2) == 0) req_idle($urandom_range(1, 3));
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_results_done();
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_set_count(CFG_CNT_W'(PH_COUNT[p]));
         eff = (PH_COUNT[p] < MAX_SLOTS_DEF) ? PH_COUNT[p] : MAX_SLOTS_DEF;
         pool_n = eff + $urandom_range(1, 4);
         if (pool_n > POOL_MAX) pool_n = POOL_MAX;
         for (int i = 0; i < pool_n; i++) begin
            id_pool[i] = $urandom;
            if (id_pool[i] == EMPTY_ID) id_pool[i] = '0;
         end
         sent = 0;
         while (sent < PH_ITEMS[p]) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < PH_ITEMS[p]; b++) begin
               if (p == HOLD_PHASE && sent == 100) hold_off_req = 1'b1;
               if (p == DRAIN_PHASE && sent == 120) wait_results_done();
               push_word(make_request(), 1'b0, NO_RSP);
               sent++;
            end
            // the hold-off phase keeps offering words so the block backs up
            if (p != HOLD_PHASE) begin
               gap = $urandom_range(0, 12);
               if (gap != 0) req_idle(gap);
            end
         end
      end

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d request words over %0d slot_count settings, 0 and 15 included",
               words_sent, N_PHASES + 1);
      $display("status mix: hit %0d, free %0d, evict %0d, no slot %0d, not found %0d, bad index %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4], status_tally[5]);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // response side stall pattern, with one long hold-off on request
   initial begin : rsp_side
      int mode, mode_left, hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_off_req) begin
            hold_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      bind_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (owed_rsp.size() == 0) begin
            $error("response word with nothing outstanding: status %0d slot %0d hits %0d",
                   rsp_status, rsp_slot_index, rsp_hit_count);
            err_count++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_slot_index !== want.slot) begin
               $error("slot_index: expected %0d, actual %0d", want.slot, rsp_slot_index);
               err_count++;
            end
            if (rsp_hit_count !== want.hits) begin
               $error("hit_count: expected %0d, actual %0d", want.hits, rsp_hit_count);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
